@@ rtl/slot_handle_table_assert.svh @@
// Assertion macros for the slot handle table RTL.
`ifndef SLOT_HANDLE_TABLE_ASSERT_SVH
`define SLOT_HANDLE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SHT_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sht_pkg.sv @@
// Types and constants shared by the slot handle table modules.
`default_nettype none

package sht_pkg;

   localparam int SLOTS      = 128;
   localparam int VALUE_BITS = 32;

   localparam int CMD_W = 3;
   localparam int SLOT_W = 8;
   localparam int VAL_W = VALUE_BITS;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int ST_W = 3;

   localparam int REQ_DATA_W = ((SLOT_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_BITS   = IDX_W + VAL_W + CNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BITS;

   typedef enum logic [CMD_W-1:0] {
      CMD_RESERVE = 3'd0,
      CMD_RELEASE = 3'd1,
      CMD_READ    = 3'd2,
      CMD_SFIRST  = 3'd3,
      CMD_SLAST   = 3'd4
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_RANGE    = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_ZERO     = 3'd5
   } status_type;

   // What the datapath needs after decoding a captured item
   typedef enum logic [1:0] {
      DEC_DONE  = 2'd0,
      DEC_RSCAN = 2'd1,
      DEC_MREAD = 2'd2,
      DEC_SSCAN = 2'd3
   } dec_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_RSCAN  = 6'b000100,
      S_MREAD  = 6'b001000,
      S_SSCAN  = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic decode;
      logic rscan;
      logic mread;
      logic sscan;
      logic commit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      dec_type dec;
      logic    rscan_hit;
      logic    sscan_done;
      logic    out_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/sht_ctrl.sv @@
// Controller state machine sequencing one item through the slot table datapath.
`default_nettype none

module sht_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  sht_pkg::dp_status_type sts_i,
   output sht_pkg::ctrl_cmd_type  cmd_o
);
   import sht_pkg::*;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd_o    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_o.capture = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd_o.decode = 1'b1;
            unique case (sts_i.dec)
               DEC_DONE:  state_in = S_FINISH;
               DEC_RSCAN: state_in = S_RSCAN;
               DEC_MREAD: state_in = S_MREAD;
               DEC_SSCAN: state_in = S_SSCAN;
               default:   state_in = S_FINISH;
            endcase
         end
         S_RSCAN: begin
            cmd_o.rscan = 1'b1;
            if (sts_i.rscan_hit) begin
               state_in = S_FINISH;
            end
         end
         S_MREAD: begin
            cmd_o.mread = 1'b1;
            state_in    = S_FINISH;
         end
         S_SSCAN: begin
            cmd_o.sscan = 1'b1;
            if (sts_i.sscan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts_i.out_free) begin
               cmd_o.commit = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/sht_dpath.sv @@
// Datapath: valid bits, value memory, pointers, occupancy and the result register.
`default_nettype none

module sht_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [sht_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [sht_pkg::CMD_W-1:0]         req_tuser,
   input  sht_pkg::ctrl_cmd_type             cmd_i,
   output sht_pkg::dp_status_type            sts_o,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sht_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [sht_pkg::ST_W-1:0]          rsp_tuser
);
   import sht_pkg::*;

   // Captured item
   cmd_type            cmd_ff, cmd_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [VAL_W-1:0]   key_ff, key_in;

   // Table state
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [IDX_W-1:0]   next_ff, next_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [VAL_W-1:0]   value_mem [SLOTS];

   // Scan pointer and visit count
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // Search pipeline: read data plus the tag of the entry it came from
   logic [VAL_W-1:0]   rd_data_ff;
   logic               rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               rd_last_ff, rd_last_in;

   // Staged result
   logic [IDX_W-1:0]   res_idx_ff, res_idx_in;
   logic [VAL_W-1:0]   res_val_ff, res_val_in;
   status_type         res_st_ff, res_st_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   out_idx_ff, out_idx_in;
   logic [VAL_W-1:0]   out_val_ff, out_val_in;
   status_type         out_st_ff, out_st_in;
   logic [CNT_W-1:0]   out_occ_ff, out_occ_in;

   logic [IDX_W-1:0]   slot_idx;
   logic               slot_oor;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   ptr_step;
   logic               match;
   logic               sscan_done;
   logic               rsv_ok;
   logic               rel_ok;
   logic [CNT_W-1:0]   occ_commit;
   dec_type            dec;
   status_type         imm_st;

   assign slot_idx = slot_ff[IDX_W-1:0];
   assign slot_oor = (32'(slot_ff) >= SLOTS);
   assign rd_addr  = cmd_i.decode ? slot_idx : ptr_ff;
   assign ptr_step = (cmd_ff == CMD_SLAST) ? ptr_ff - IDX_W'(1) : ptr_ff + IDX_W'(1);

   // Search compare on the entry read last cycle
   assign match      = rd_pend_ff && rd_vld_ff && (rd_data_ff == key_ff);
   assign sscan_done = match || (rd_pend_ff && rd_last_ff);

   // Decode of the captured item
   always_comb begin
      dec    = DEC_DONE;
      imm_st = ST_RANGE;
      unique case (cmd_ff)
         CMD_RESERVE: begin
            if (key_ff == '0) begin
               imm_st = ST_ZERO;
            end else if (32'(occ_ff) >= SLOTS) begin
               imm_st = ST_FULL;
            end else begin
               dec = DEC_RSCAN;
            end
         end
         CMD_RELEASE, CMD_READ: begin
            if (slot_oor) begin
               imm_st = ST_RANGE;
            end else if (!valid_ff[slot_idx]) begin
               imm_st = ST_EMPTY;
            end else begin
               dec = DEC_MREAD;
            end
         end
         CMD_SFIRST, CMD_SLAST: dec = DEC_SSCAN;
         default:               imm_st = ST_RANGE;
      endcase
   end

   assign rsv_ok = (cmd_ff == CMD_RESERVE) && (res_st_ff == ST_OK);
   assign rel_ok = (cmd_ff == CMD_RELEASE) && (res_st_ff == ST_OK);

   always_comb begin
      priority if (rsv_ok) begin
         occ_commit = occ_ff + CNT_W'(1);
      end else if (rel_ok) begin
         occ_commit = occ_ff - CNT_W'(1);
      end else begin
         occ_commit = occ_ff;
      end
   end

   assign sts_o.dec        = dec;
   assign sts_o.rscan_hit  = !valid_ff[ptr_ff];
   assign sts_o.sscan_done = sscan_done;
   assign sts_o.out_free   = !rsp_valid_ff || rsp_tready;

   // Next values for all datapath registers
   always_comb begin
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      key_in       = key_ff;
      valid_in     = valid_ff;
      next_in      = next_ff;
      occ_in       = occ_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      rd_pend_in   = rd_pend_ff;
      rd_idx_in    = rd_idx_ff;
      rd_vld_in    = rd_vld_ff;
      rd_last_in   = rd_last_ff;
      res_idx_in   = res_idx_ff;
      res_val_in   = res_val_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff;
      out_idx_in   = out_idx_ff;
      out_val_in   = out_val_ff;
      out_st_in    = out_st_ff;
      out_occ_in   = out_occ_ff;

      if (cmd_i.capture) begin
         cmd_in  = cmd_type'(req_tuser);
         slot_in = req_tdata[SLOT_W-1:0];
         key_in  = req_tdata[SLOT_W +: VAL_W];
      end

      // Immediate outcome, scan start point
      if (cmd_i.decode) begin
         rd_pend_in = 1'b0;
         cnt_in     = '0;
         res_idx_in = '0;
         res_val_in = '0;
         res_st_in  = imm_st;
         if (dec == DEC_RSCAN) begin
            ptr_in = next_ff;
         end else if (cmd_ff == CMD_SLAST) begin
            ptr_in = IDX_W'(SLOTS - 1);
         end else begin
            ptr_in = '0;
         end
      end

      // Circular walk over valid bits for a free slot
      if (cmd_i.rscan) begin
         if (!valid_ff[ptr_ff]) begin
            res_idx_in = ptr_ff;
            res_st_in  = ST_OK;
         end else begin
            ptr_in = ptr_ff + IDX_W'(1);
         end
      end

      if (cmd_i.mread) begin
         res_idx_in = slot_idx;
         res_val_in = rd_data_ff;
         res_st_in  = ST_OK;
      end

      // One entry issued and one compared per cycle
      if (cmd_i.sscan) begin
         ptr_in     = ptr_step;
         cnt_in     = cnt_ff + CNT_W'(1);
         rd_idx_in  = ptr_ff;
         rd_vld_in  = valid_ff[ptr_ff];
         rd_last_in = (cnt_ff == CNT_W'(SLOTS - 1));
         rd_pend_in = !sscan_done;
         if (match) begin
            res_idx_in = rd_idx_ff;
            res_st_in  = ST_OK;
         end else if (sscan_done) begin
            res_idx_in = '0;
            res_st_in  = ST_NOTFOUND;
         end
      end

      // Apply the table update and load the output register
      if (cmd_i.commit) begin
         rsp_valid_in = 1'b1;
         out_idx_in   = res_idx_ff;
         out_val_in   = res_val_ff;
         out_st_in    = res_st_ff;
         out_occ_in   = occ_commit;
         occ_in       = occ_commit;
         if (rsv_ok) begin
            valid_in[res_idx_ff] = 1'b1;
            next_in              = res_idx_ff + IDX_W'(1);
         end
         if (rel_ok) begin
            valid_in[res_idx_ff] = 1'b0;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         next_ff      <= '0;
         occ_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         next_ff      <= next_in;
         occ_ff       <= occ_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      slot_ff    <= slot_in;
      key_ff     <= key_in;
      ptr_ff     <= ptr_in;
      cnt_ff     <= cnt_in;
      rd_idx_ff  <= rd_idx_in;
      rd_vld_ff  <= rd_vld_in;
      rd_last_ff <= rd_last_in;
      res_idx_ff <= res_idx_in;
      res_val_ff <= res_val_in;
      res_st_ff  <= res_st_in;
      out_idx_ff <= out_idx_in;
      out_val_ff <= out_val_in;
      out_st_ff  <= out_st_in;
      out_occ_ff <= out_occ_in;
   end

   // Value memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= value_mem[rd_addr];
      if (cmd_i.commit && rsv_ok) begin
         value_mem[res_idx_ff] <= key_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_occ_ff, out_val_ff, out_idx_ff};
   assign rsp_tuser  = out_st_ff;

endmodule

`default_nettype wire

@@ rtl/slot_handle_table.sv @@
// Slot handle table: 128 value slots, reserve/release/read/search, one result per item.
//
// Request channel (req_): command in tuser, slot and value in tdata. The block
// takes one item at a time; req_tready is high while the controller is idle.
// Response channel (rsp_): one result item per request, status in tuser and
// slot index, value and occupancy in tdata, held in an output register.
// After capture and decode, each item takes its own step before the commit:
//   immediate outcomes (zero value, full, out of range, empty slot): none
//   release, read: one registered value-memory read
//   reserve: 1..128 slots walked from the rotating next pointer
//   search first/last: 1..128 entries read through the memory port
// The next item can be accepted as soon as the result is loaded; the reserve
// and search scans take one slot or entry per cycle.
// A waiting result does not block acceptance; a stalled receiver holds the
// current result and the controller waits only to load the following one.
// Reset clears all valid bits, the next pointer and the occupancy at once.
`default_nettype none

module slot_handle_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] slot, [39:8] value
   input  logic [sht_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [2:0] command
   input  logic [sht_pkg::CMD_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [6:0] slot_index, [38:7] slot_value, [46:39] occupied_count, [47] zero
   output logic [sht_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [2:0] status
   output logic [sht_pkg::ST_W-1:0]        rsp_tuser
);
   import sht_pkg::*;

   ctrl_cmd_type     cmd_s;
   dp_status_type    sts_s;
   logic [5:0]       work_cmds;
   logic [CNT_W-1:0] rsp_occ;
   logic             req_take;

   sht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts_i      (sts_s),
      .cmd_o      (cmd_s)
   );

   sht_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_i      (cmd_s),
      .sts_o      (sts_s),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Checks
   assign work_cmds = {cmd_s.capture, cmd_s.decode, cmd_s.rscan,
                       cmd_s.mread, cmd_s.sscan, cmd_s.commit};
   assign rsp_occ   = rsp_tdata[IDX_W + VAL_W +: CNT_W];
   assign req_take  = req_tvalid && req_tready;

`include "slot_handle_table_assert.svh"

   `SHT_ASSERT_NEXT(a_take_decode, clock, reset, req_take, cmd_s.decode, "item not decoded")
   `SHT_ASSERT_HOLDS(a_commit_free, clock, reset, cmd_s.commit, sts_s.out_free, "result overrun")
   `SHT_ASSERT_HOLDS(a_one_cmd, clock, reset, 1'b1, $onehot0(work_cmds), "commands overlap")
   `SHT_ASSERT_HOLDS(a_occ_max, clock, reset, rsp_tvalid, 32'(rsp_occ) <= SLOTS, "occupancy high")

endmodule

`default_nettype wire

@@ tb/sv/tb_slot_handle_table.sv @@
// Stream testbench for the slot handle table: directed and random commands, scoreboard check.
`default_nettype none

module tb_slot_handle_table;
   timeunit 1ns;
   timeprecision 1ps;

   import sht_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 200;
   localparam int POOL_SIZE = 12;

   // One command as queued for the driver
   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [SLOT_W-1:0] slot;
      logic [VAL_W-1:0]  value;
      bit                sync;   // wait for every outstanding result first
   } table_cmd_type;

   // One expected result item
   typedef struct {
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] val;
      status_type       st;
      logic [CNT_W-1:0] cnt;
   } table_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [ST_W-1:0]       rsp_tuser;

   slot_handle_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Shadow table
   logic [VAL_W-1:0] shadow_val [SLOTS];
   bit               shadow_used [SLOTS];
   int               shadow_next;
   int               shadow_occ;

   table_cmd_type    pending_cmds[$];
   table_result_type expected_results[$];

   logic [VAL_W-1:0] key_pool [POOL_SIZE];

   // Handshake flags seen at the last rising edge
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;

   int n_req, n_rsp, n_errors, idle_cycles;
   int peak_occ, n_full, n_found;
   int send_gap, send_burst, recv_gap, recv_burst, hold_left;
   table_cmd_type    cur_cmd;
   table_result_type want, got;
   bit               next_valid, next_ready;

   initial begin
      forever #5 clock = ~clock;
   end

   // Compute the result of one command and update the shadow table
   function automatic table_result_type apply_command(logic [CMD_W-1:0] cmd,
                                                      logic [SLOT_W-1:0] slot,
                                                      logic [VAL_W-1:0] key);
      table_result_type r;
      int pos;
      bit hit;
      r.idx = '0;
      r.val = '0;
      r.st = ST_OK;
      hit = 1'b0;
      case (cmd)
         CMD_RESERVE: begin
            if (key == '0) begin
               r.st = ST_ZERO;
            end else if (shadow_occ >= SLOTS) begin
               r.st = ST_FULL;
            end else begin
               pos = shadow_next;
               for (int i = 0; i < SLOTS && !hit; i++) begin
                  if (!shadow_used[pos]) begin
                     shadow_val[pos] = key;
                     shadow_used[pos] = 1'b1;
                     shadow_next = (pos + 1) % SLOTS;
                     shadow_occ++;
                     r.idx = pos[IDX_W-1:0];
                     hit = 1'b1;
                  end else begin
                     pos = (pos + 1) % SLOTS;
                  end
               end
               if (!hit) r.st = ST_FULL;
            end
         end
         CMD_RELEASE, CMD_READ: begin
            if (slot >= SLOTS) begin
               r.st = ST_RANGE;
            end else if (!shadow_used[slot]) begin
               r.st = ST_EMPTY;
            end else begin
               r.idx = slot[IDX_W-1:0];
               r.val = shadow_val[slot];
               if (cmd == CMD_RELEASE) begin
                  shadow_used[slot] = 1'b0;
                  shadow_val[slot] = '0;
                  if (shadow_occ > 0) shadow_occ--;
               end
            end
         end
         CMD_SFIRST: begin
            for (int i = 0; i < SLOTS && !hit; i++) begin
               if (shadow_used[i] && shadow_val[i] == key) begin
                  r.idx = i[IDX_W-1:0];
                  hit = 1'b1;
               end
            end
            if (!hit) r.st = ST_NOTFOUND;
         end
         CMD_SLAST: begin
            for (int i = SLOTS - 1; i >= 0 && !hit; i--) begin
               if (shadow_used[i] && shadow_val[i] == key) begin
                  r.idx = i[IDX_W-1:0];
                  hit = 1'b1;
               end
            end
            if (!hit) r.st = ST_NOTFOUND;
         end
         default: r.st = ST_RANGE;
      endcase
      r.cnt = shadow_occ[CNT_W-1:0];
      return r;
   endfunction

   // Wait drawn per item, with occasional stretches of no waiting
   function automatic int draw_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
      n_errors++;
      if (n_errors <= 30)
         $display("MISMATCH result %0d %s: expected 0x%0h got 0x%0h", n_rsp, what, exp_v, got_v);
   endtask

   task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                            logic [VAL_W-1:0] value, bit sync = 1'b0);
      table_cmd_type c;
      c.cmd = cmd;
      c.slot = slot;
      c.value = value;
      c.sync = sync;
      pending_cmds.push_back(c);
   endtask

   // Random commands with the given mix; keys mostly from a small pool so searches hit
   task automatic gen_phase(int n, int w_res, int w_rel, int w_rd, int w_srch, int w_bad,
                            bit sync_first);
      int pick, total;
      logic [VAL_W-1:0] key;
      logic [SLOT_W-1:0] slot;
      total = w_res + w_rel + w_rd + w_srch + w_bad;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, total - 1);
         key = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : $urandom;
         slot = SLOT_W'($urandom_range(0, SLOTS - 1));
         if (pick < w_res) begin
            queue_cmd(CMD_RESERVE, SLOT_W'($urandom), key, sync_first && k == 0);
         end else if (pick < w_res + w_rel) begin
            queue_cmd(CMD_RELEASE, slot, $urandom, sync_first && k == 0);
         end else if (pick < w_res + w_rel + w_rd) begin
            queue_cmd(CMD_READ, slot, $urandom, sync_first && k == 0);
         end else if (pick < total - w_bad) begin
            queue_cmd($urandom_range(0, 1) ? CMD_SFIRST : CMD_SLAST, SLOT_W'($urandom), key,
                      sync_first && k == 0);
         end else begin
            // broken items: bad codes, slots past the table, zero values
            case ($urandom_range(0, 3))
               0: queue_cmd(CMD_W'($urandom_range(5, 7)), SLOT_W'($urandom), $urandom,
                            sync_first && k == 0);
               1: queue_cmd($urandom_range(0, 1) ? CMD_RELEASE : CMD_READ,
                            SLOT_W'($urandom_range(SLOTS, 255)), $urandom,
                            sync_first && k == 0);
               2: queue_cmd(CMD_RESERVE, SLOT_W'($urandom), '0, sync_first && k == 0);
               default: queue_cmd($urandom_range(0, 1) ? CMD_SFIRST : CMD_SLAST,
                                  SLOT_W'($urandom), '0, sync_first && k == 0);
            endcase
         end
      end
   endtask

   // Sampling at the rising edge: predict on accepted commands, check accepted results
   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
         rsp_took <= 1'b0;
      end else begin
         req_took <= req_tvalid && req_tready;
         rsp_took <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) begin
            want = apply_command(req_tuser, req_tdata[SLOT_W-1:0],
                                 req_tdata[SLOT_W +: VAL_W]);
            expected_results.push_back(want);
            n_req++;
            if (shadow_occ > peak_occ) peak_occ = shadow_occ;
            if (want.st == ST_FULL) n_full++;
            if (want.st == ST_OK && (req_tuser == CMD_SFIRST || req_tuser == CMD_SLAST))
               n_found++;
         end
         if (rsp_tvalid && rsp_tready) begin
            n_rsp++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               got.idx = rsp_tdata[IDX_W-1:0];
               got.val = rsp_tdata[IDX_W +: VAL_W];
               got.cnt = rsp_tdata[IDX_W + VAL_W +: CNT_W];
               if (rsp_tuser !== want.st) report_mismatch("status", want.st, rsp_tuser);
               if (got.idx !== want.idx) report_mismatch("slot_index", want.idx, got.idx);
               if (got.val !== want.val) report_mismatch("slot_value", want.val, got.val);
               if (got.cnt !== want.cnt)
                  report_mismatch("occupied_count", want.cnt, got.cnt);
               if (rsp_tdata[RSP_DATA_W-1:RSP_BITS] !== '0)
                  report_mismatch("padding", '0, rsp_tdata[RSP_DATA_W-1:RSP_BITS]);
            end
         end
         // watchdog on cycles with no handshake at all
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
               $display("tb_slot_handle_table failed");
               $finish;
            end
         end
      end
   end

   // Command driver, falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_took) send_gap = draw_wait(send_burst);
         if (req_tvalid && !req_took) begin
            next_valid = 1'b1;
         end else if (send_gap > 0) begin
            send_gap--;
            next_valid = 1'b0;
         end else if (pending_cmds.size() != 0 &&
                      !(pending_cmds[0].sync && expected_results.size() != 0)) begin
            cur_cmd = pending_cmds.pop_front();
            req_tdata <= {cur_cmd.value, cur_cmd.slot};
            req_tuser <= cur_cmd.cmd;
            next_valid = 1'b1;
         end else begin
            next_valid = 1'b0;
         end
         req_tvalid <= next_valid;
      end
   end

   // Result receiver, falling edge; two long hold-offs let the block back up
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_took) begin
            recv_gap = draw_wait(recv_burst);
            if (n_rsp == 40 || n_rsp == 800) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_tready <= next_ready;
      end
   end

   // Stimulus and end of run
   initial begin
      shadow_next = 0;
      shadow_occ = 0;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_used[i] = 1'b0;
         shadow_val[i] = '0;
      end
      key_pool[0] = 32'hFFFF_FFFF;
      key_pool[1] = 32'h0000_0001;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h5555_5555;
      key_pool[4] = 32'hAAAA_AAAA;
      for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom | 32'h1;

      // directed: empty-table corner cases, bad codes, rotation, duplicates
      queue_cmd(CMD_RESERVE, 8'd0, 32'h0);
      queue_cmd(CMD_SFIRST, 8'd0, 32'h0);
      queue_cmd(CMD_SLAST, 8'd0, 32'h1234);
      queue_cmd(CMD_READ, 8'd0, 32'h0);
      queue_cmd(CMD_RELEASE, 8'd255, 32'h0);
      queue_cmd(CMD_READ, 8'd128, 32'h0);
      queue_cmd(3'd5, 8'd255, 32'hFFFF_FFFF);
      queue_cmd(3'd6, 8'd0, 32'h0);
      queue_cmd(3'd7, 8'd127, 32'h1);
      queue_cmd(CMD_RESERVE, 8'd255, 32'hFFFF_FFFF);
      queue_cmd(CMD_RESERVE, 8'd0, 32'h1);
      queue_cmd(CMD_RESERVE, 8'd0, 32'hFFFF_FFFF);
      queue_cmd(CMD_RESERVE, 8'd0, 32'h8000_0000);
      queue_cmd(CMD_SFIRST, 8'd0, 32'hFFFF_FFFF);
      queue_cmd(CMD_SLAST, 8'd0, 32'hFFFF_FFFF);
      queue_cmd(CMD_SFIRST, 8'd0, 32'h0);
      queue_cmd(CMD_READ, 8'd1, 32'h0);
      queue_cmd(CMD_RELEASE, 8'd1, 32'h0);
      queue_cmd(CMD_RELEASE, 8'd1, 32'h0);
      queue_cmd(CMD_READ, 8'd1, 32'h0);
      queue_cmd(CMD_RESERVE, 8'd0, 32'h5);
      queue_cmd(CMD_READ, 8'd127, 32'h0);
      queue_cmd(CMD_RELEASE, 8'd0, 32'h0);
      queue_cmd(CMD_SLAST, 8'd0, 32'hFFFF_FFFF);
      queue_cmd(CMD_RELEASE, 8'd127, 32'h0);

      // random: fill past full, churn, drain, refill, churn
      gen_phase(200, 90, 2, 3, 3, 2, 1'b0);
      gen_phase(350, 30, 25, 15, 20, 10, 1'b1);
      gen_phase(300, 10, 65, 10, 10, 5, 1'b0);
      gen_phase(180, 80, 5, 5, 5, 5, 1'b1);
      gen_phase(300, 30, 30, 15, 15, 10, 1'b0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d commands and %0d results, peak occupancy %0d", n_req, n_rsp,
               peak_occ);
      $display("table-full rejects %0d, search hits %0d, mismatches %0d", n_full, n_found,
               n_errors);
      if (n_errors == 0 && expected_results.size() == 0) begin
         $display("tb_slot_handle_table passed");
      end else begin
         $display("tb_slot_handle_table failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
